/* rtl/csd_pkg.sv */
// Shared types and character constants for the escape sequence decoder.
package csd_pkg;

	typedef enum logic [1:0] {
		MODE_NORMAL = 2'd0,
		MODE_ESC    = 2'd1,
		MODE_HEX    = 2'd2,
		MODE_OCT    = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t       mode;
		logic [1:0]  count;
		logic [8:0]  accum;
	} state_t;

	localparam state_t STATE_RESET = '{MODE_NORMAL, 2'd0, 9'd0};

	// One result of the decoder as it appears on the output port.
	typedef struct packed {
		logic [7:0] data;
		logic       char_valid;
		logic       run_last;
		logic       string_done;
	} res_t;

	// Everything one input byte produces: up to two results in order.
	typedef struct packed {
		logic [1:0] count;
		res_t       first;
		res_t       second;
	} step_out_t;

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_7      = 8'h37;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_LC_A   = 8'h61;
	localparam logic [7:0] CH_LC_F   = 8'h66;
	localparam logic [7:0] CH_UC_A   = 8'h41;
	localparam logic [7:0] CH_UC_F   = 8'h46;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_V      = 8'h76;
	localparam logic [7:0] CH_X      = 8'h78;

	localparam logic [7:0] CODE_BS = 8'h08;
	localparam logic [7:0] CODE_FF = 8'h0C;
	localparam logic [7:0] CODE_LF = 8'h0A;
	localparam logic [7:0] CODE_CR = 8'h0D;
	localparam logic [7:0] CODE_HT = 8'h09;
	localparam logic [7:0] CODE_VT = 8'h0B;

endpackage

/* rtl/csd_step.sv */
// Combinational decode of one byte: next decoder state and the results it causes.
module csd_step (
	input  csd_pkg::state_t    cur,
	input  logic [7:0]         in_char,
	input  logic               string_end,
	output csd_pkg::state_t    nxt,
	output csd_pkg::step_out_t res
);
	import csd_pkg::*;

	logic       hex_ok;
	logic [3:0] hex_val;
	logic       oct_ok;
	logic       fall;
	mode_t      fall_mode;
	logic       emit_num;
	logic       emit_chr;
	logic       emit_end;
	logic [7:0] num_val;
	logic [7:0] chr_val;
	logic [7:0] end_val;
	logic [1:0] cnt_n;
	logic [8:0] acc_n;
	state_t     st;
	logic [1:0] n;
	res_t       res_a;
	res_t       res_b;

	always_comb begin
		hex_ok  = 1'b1;
		hex_val = 4'd0;
		if (in_char inside {[CH_0:CH_9]}) begin
			hex_val = in_char[3:0];
		end else if (in_char inside {[CH_LC_A:CH_LC_F], [CH_UC_A:CH_UC_F]}) begin
			hex_val = in_char[3:0] + 4'd9;
		end else begin
			hex_ok = 1'b0;
		end
		oct_ok = in_char inside {[CH_0:CH_7]};
	end

	always_comb begin
		st        = cur;
		fall      = 1'b1;
		fall_mode = cur.mode;
		emit_num  = 1'b0;
		emit_chr  = 1'b0;
		num_val   = cur.accum[7:0];
		chr_val   = in_char;
		cnt_n     = cur.count + 2'd1;
		acc_n     = cur.accum;

		case (cur.mode)
			MODE_OCT: begin
				if (oct_ok) begin
					fall  = 1'b0;
					acc_n = {cur.accum[5:0], in_char[2:0]};
					if (cnt_n == 2'd3 || cnt_n == 2'd0) begin
						emit_num = 1'b1;
						num_val  = acc_n[7:0];
						st       = STATE_RESET;
					end else begin
						st = '{MODE_OCT, cnt_n, acc_n};
					end
				end else begin
					emit_num  = 1'b1;
					st        = STATE_RESET;
					fall_mode = MODE_NORMAL;
				end
			end
			MODE_HEX: begin
				if (hex_ok) begin
					fall  = 1'b0;
					acc_n = {cur.accum[4:0], hex_val};
					if (cnt_n[1] || cnt_n == 2'd0) begin
						emit_num = 1'b1;
						num_val  = acc_n[7:0];
						st       = STATE_RESET;
					end else begin
						st = '{MODE_HEX, cnt_n, acc_n};
					end
				end else begin
					// An x escape with no digits emits nothing.
					emit_num  = (cur.count != 2'd0);
					st        = STATE_RESET;
					fall_mode = MODE_NORMAL;
				end
			end
			default: begin
			end
		endcase

		if (fall) begin
			case (fall_mode)
				MODE_NORMAL: begin
					if (in_char == CH_BSLASH) begin
						st.mode = MODE_ESC;
					end else begin
						emit_chr = 1'b1;
					end
				end
				MODE_ESC: begin
					st.mode = MODE_NORMAL;
					case (in_char)
						CH_B: begin emit_chr = 1'b1; chr_val = CODE_BS; end
						CH_F: begin emit_chr = 1'b1; chr_val = CODE_FF; end
						CH_N: begin emit_chr = 1'b1; chr_val = CODE_LF; end
						CH_R: begin emit_chr = 1'b1; chr_val = CODE_CR; end
						CH_T: begin emit_chr = 1'b1; chr_val = CODE_HT; end
						CH_V: begin emit_chr = 1'b1; chr_val = CODE_VT; end
						CH_X: begin
							st = '{MODE_HEX, 2'd0, 9'd0};
						end
						default: begin
							if (oct_ok) begin
								st = '{MODE_OCT, 2'd1, {6'd0, in_char[2:0]}};
							end else begin
								emit_chr = 1'b1;
							end
						end
					endcase
				end
				default: begin
				end
			endcase
		end

		// A number still open at the end of the string is flushed.
		emit_end = string_end &&
			((st.mode == MODE_HEX && st.count != 2'd0) || st.mode == MODE_OCT);
		end_val  = st.accum[7:0];
		nxt      = string_end ? STATE_RESET : st;
	end

	always_comb begin
		n = {1'b0, emit_num} + {1'b0, emit_chr} + {1'b0, emit_end};

		res_a.data        = emit_num ? num_val : (emit_chr ? chr_val : end_val);
		res_a.char_valid  = 1'b1;
		res_a.run_last    = (n == 2'd1);
		res_a.string_done = (n == 2'd1) && string_end;

		res_b.data        = (emit_num && emit_chr) ? chr_val : end_val;
		res_b.char_valid  = 1'b1;
		res_b.run_last    = 1'b1;
		res_b.string_done = string_end;

		// A final byte that decodes to nothing still closes the string.
		if (string_end && n == 2'd0) begin
			n     = 2'd1;
			res_a = '{8'd0, 1'b0, 1'b1, 1'b1};
		end

		res.count  = n;
		res.first  = res_a;
		res.second = res_b;
	end

endmodule

/* rtl/c_escape_sequence_decoder_core.sv */
// A byte accepted into the input stage register is decoded from there, and its results go
// into the result register, which drives the output. Throughput: one byte per cycle while
// the result register has room, which a byte with two results fills.
// The output side drains one result per unstalled cycle from a two-entry result register.
// Reset: arst_n asynchronously clears the decoder state, the input stage valid
// and the result fill count; payload registers are not reset.
module c_escape_sequence_decoder_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  logic [7:0] in_char,
	input  logic       string_end,
	output logic       result_valid,
	input  logic       result_stall,
	output logic [7:0] out_char,
	output logic       char_valid,
	output logic       run_last,
	output logic       string_done
);
	import csd_pkg::*;

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       end_s1;
	state_t     state_q;
	state_t     state_nxt;
	step_out_t  step_res;
	res_t       entry0_q;
	res_t       entry1_q;
	logic [1:0] fill_q;
	logic       out_xfer;
	logic       item_xfer;
	logic       room;
	logic       fire;

	csd_step u_step (
		.cur        (state_q),
		.in_char    (char_s1),
		.string_end (end_s1),
		.nxt        (state_nxt),
		.res        (step_res)
	);

	assign result_valid = (fill_q != 2'd0);
	assign out_xfer     = result_valid && !result_stall;
	// The result register can take a new pair once its last entry leaves.
	assign room         = (fill_q == 2'd0) || (fill_q == 2'd1 && out_xfer);
	assign fire         = valid_s1 && (step_res.count == 2'd0 || room);
	assign item_stall   = valid_s1 && !fire;
	assign item_xfer    = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			state_q  <= STATE_RESET;
			fill_q   <= 2'd0;
		end else begin
			if (item_xfer) begin
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
			if (fire) begin
				state_q <= state_nxt;
			end
			if (fire && step_res.count != 2'd0) begin
				fill_q <= step_res.count;
			end else if (out_xfer) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_xfer) begin
			char_s1 <= in_char;
			end_s1  <= string_end;
		end
		if (fire && step_res.count != 2'd0) begin
			entry0_q <= step_res.first;
			entry1_q <= step_res.second;
		end else if (out_xfer) begin
			entry0_q <= entry1_q;
		end
	end

	assign out_char    = entry0_q.data;
	assign char_valid  = entry0_q.char_valid;
	assign run_last    = entry0_q.run_last;
	assign string_done = entry0_q.string_done;

endmodule

/* rtl/csd_checker.sv */
// Port-level checks for the escape sequence decoder and their bind to the top level.
module csd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       result_valid,
	input logic       result_stall,
	input logic [7:0] out_char,
	input logic       char_valid,
	input logic       run_last,
	input logic       string_done
);

	// A stalled result holds until its transfer.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=>
			result_valid && $stable(out_char) && $stable(char_valid) &&
			$stable(run_last) && $stable(string_done))
	else $error("stalled result changed");

	// The end of a string is always the last result of its byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && string_done |-> run_last)
	else $error("string_done without run_last");

	// A bare end marker carries a zero byte and closes the string.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !char_valid |-> run_last && string_done && out_char == 8'd0)
	else $error("malformed end marker");

	// The second result of a byte is already buffered behind the first.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && !run_last |=> result_valid)
	else $error("second result of a byte missing");

endmodule

bind c_escape_sequence_decoder_core csd_checker u_csd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.out_char     (out_char),
	.char_valid   (char_valid),
	.run_last     (run_last),
	.string_done  (string_done)
);

/* test/tb_c_escape_sequence_decoder_core.sv */
// Self-checking testbench for the C escape sequence decoder core.
module tb_c_escape_sequence_decoder_core;
	import csd_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int MAX_REPORTS = 10;
	localparam int PHASE_ITEMS = 280;
	localparam int DRAIN_CYCLES = 20;

	typedef struct {
		logic [7:0] ch;
		logic       fin;
		int         n_typed;
		res_t       typed_res;
	} dir_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       item_valid = 1'b0;
	logic       item_stall;
	logic [7:0] in_char = 8'h00;
	logic       string_end = 1'b0;
	logic       result_valid;
	logic       result_stall = 1'b0;
	logic [7:0] out_char;
	logic       char_valid;
	logic       run_last;
	logic       string_done;

	// Decoder state as the testbench sees it.
	mode_t      esc_mode = MODE_NORMAL;
	logic [1:0] num_digits = 2'd0;
	logic [8:0] num_value = 9'd0;

	res_t       step_res [2];
	int         step_cnt;
	res_t       expected_out [$];
	dir_row_t   rows [$];

	int mismatches = 0;
	int cycles = 0;
	int items_sent = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;

	c_escape_sequence_decoder_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.in_char(in_char),
		.string_end(string_end),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.out_char(out_char),
		.char_valid(char_valid),
		.run_last(run_last),
		.string_done(string_done)
	);

	always #10 clk = ~clk;

	function automatic res_t decoded(input logic [7:0] d, input logic v, input logic l,
			input logic s);
		return {d, v, l, s};
	endfunction

	function automatic void put_byte(input logic [7:0] v);
		step_res[1'(step_cnt)] = decoded(v, 1'b1, 1'b0, 1'b0);
		step_cnt++;
	endfunction

	function automatic void clear_number();
		esc_mode = MODE_NORMAL;
		num_digits = 2'd0;
		num_value = 9'd0;
	endfunction

	function automatic int hex_digit(input logic [7:0] c);
		if (c >= CH_0 && c <= CH_9)
			return int'(c) - int'(CH_0);
		if (c >= CH_LC_A && c <= CH_LC_F)
			return int'(c) - int'(CH_LC_A) + 10;
		if (c >= CH_UC_A && c <= CH_UC_F)
			return int'(c) - int'(CH_UC_A) + 10;
		return -1;
	endfunction

	// Decodes one byte and leaves the results it causes in step_res.
	function automatic void decode_byte(input logic [7:0] c, input logic fin);
		int   hv;
		logic taken;
		taken = 1'b0;
		step_cnt = 0;
		hv = hex_digit(c);
		if (esc_mode == MODE_OCT) begin
			if (c >= CH_0 && c <= CH_7) begin
				num_value = (num_value << 3) + 9'(c - CH_0);
				num_digits = num_digits + 2'd1;
				taken = 1'b1;
				if (num_digits == 2'd3 || num_digits == 2'd0) begin
					put_byte(num_value[7:0]);
					clear_number();
				end
			end else begin
				put_byte(num_value[7:0]);
				clear_number();
			end
		end else if (esc_mode == MODE_HEX) begin
			if (hv >= 0) begin
				num_value = (num_value << 4) + 9'(hv);
				num_digits = num_digits + 2'd1;
				taken = 1'b1;
				if (num_digits >= 2'd2 || num_digits == 2'd0) begin
					put_byte(num_value[7:0]);
					clear_number();
				end
			end else begin
				if (num_digits != 2'd0)
					put_byte(num_value[7:0]);
				clear_number();
			end
		end

		if (!taken) begin
			if (esc_mode == MODE_NORMAL) begin
				if (c == CH_BSLASH)
					esc_mode = MODE_ESC;
				else
					put_byte(c);
			end else if (esc_mode == MODE_ESC) begin
				esc_mode = MODE_NORMAL;
				case (c)
					CH_B: put_byte(CODE_BS);
					CH_F: put_byte(CODE_FF);
					CH_N: put_byte(CODE_LF);
					CH_R: put_byte(CODE_CR);
					CH_T: put_byte(CODE_HT);
					CH_V: put_byte(CODE_VT);
					CH_X: begin
						esc_mode = MODE_HEX;
						num_digits = 2'd0;
						num_value = 9'd0;
					end
					default: begin
						if (c >= CH_0 && c <= CH_7) begin
							esc_mode = MODE_OCT;
							num_digits = 2'd1;
							num_value = 9'(c - CH_0);
						end else begin
							put_byte(c);
						end
					end
				endcase
			end
		end

		if (fin) begin
			if ((esc_mode == MODE_HEX && num_digits != 2'd0) || esc_mode == MODE_OCT)
				put_byte(num_value[7:0]);
			clear_number();
			// A string end that decodes to nothing still gets a bare end marker.
			if (step_cnt == 0) begin
				step_res[0] = decoded(8'h00, 1'b0, 1'b0, 1'b0);
				step_cnt = 1;
			end
			step_res[1'(step_cnt - 1)].string_done = 1'b1;
		end
		if (step_cnt > 0)
			step_res[1'(step_cnt - 1)].run_last = 1'b1;
	endfunction

	function automatic void report(input string what);
		if (mismatches < MAX_REPORTS)
			$display("ERROR at cycle %0d: %s", cycles, what);
		mismatches++;
	endfunction

	function automatic void add_row(input logic [7:0] ch, input logic fin, input int n,
			input res_t r);
		dir_row_t row;
		row.ch = ch;
		row.fin = fin;
		row.n_typed = n;
		row.typed_res = r;
		rows.push_back(row);
	endfunction

	// Presents one byte, waits for its transfer and records what it should produce.
	// A negative n_typed means the expectation comes from the predictor.
	task automatic send_item(input logic [7:0] ch, input logic fin, input int n_typed,
			input res_t typed_res);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		in_char <= ch;
		string_end <= fin;
		@(posedge clk);
		while (item_stall !== 1'b0)
			@(posedge clk);
		decode_byte(ch, fin);
		if (n_typed >= 0) begin
			if (n_typed > 0)
				expected_out.push_back(typed_res);
		end else begin
			for (int i = 0; i < step_cnt; i++)
				expected_out.push_back(step_res[1'(i)]);
		end
	endtask

	// Sends one token: mostly well-formed escapes with random content, some noise.
	task automatic send_token();
		int         kind;
		int         k;
		int         v;
		logic [7:0] seq [$];
		kind = $urandom_range(99);
		if (kind < 30) begin
			seq.push_back(8'($urandom_range(126, 32)));
		end else if (kind < 45) begin
			seq.push_back(CH_BSLASH);
			case ($urandom_range(6))
				0: seq.push_back(CH_B);
				1: seq.push_back(CH_F);
				2: seq.push_back(CH_N);
				3: seq.push_back(CH_R);
				4: seq.push_back(CH_T);
				5: seq.push_back(CH_V);
				default: seq.push_back(8'($urandom_range(255)));
			endcase
		end else if (kind < 62) begin
			seq.push_back(CH_BSLASH);
			seq.push_back(CH_X);
			k = $urandom_range(3);
			repeat (k) begin
				v = $urandom_range(15);
				if (v < 10)
					seq.push_back(CH_0 + 8'(v));
				else if ($urandom_range(1))
					seq.push_back(CH_LC_A + 8'(v - 10));
				else
					seq.push_back(CH_UC_A + 8'(v - 10));
			end
		end else if (kind < 82) begin
			seq.push_back(CH_BSLASH);
			k = $urandom_range(4, 1);
			repeat (k)
				seq.push_back(CH_0 + 8'($urandom_range(7)));
		end else if (kind < 87) begin
			seq.push_back(CH_BSLASH);
			seq.push_back($urandom_range(1) ? CH_9 : CH_9 - 8'd1);
		end else begin
			seq.push_back(8'($urandom_range(255)));
		end
		foreach (seq[i])
			send_item(seq[i], $urandom_range(11) == 0, -1, '0);
		items_sent += seq.size();
	endtask

	task automatic run_phase(input int idle_pct, input int stl_pct, input int n_items);
		int first;
		send_idle_pct = idle_pct;
		stall_pct = stl_pct;
		first = items_sent;
		while (items_sent - first < n_items)
			send_token();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		add_row(8'h00, 1'b0, 1, decoded(8'h00, 1'b1, 1'b1, 1'b0));
		add_row(8'hFF, 1'b0, 1, decoded(8'hFF, 1'b1, 1'b1, 1'b0));
		add_row(CH_BSLASH, 1'b0, 0, '0);
		add_row(CH_B, 1'b0, 1, decoded(CODE_BS, 1'b1, 1'b1, 1'b0));
		add_row(CH_BSLASH, 1'b0, 0, '0);
		add_row(CH_F, 1'b0, 1, decoded(CODE_FF, 1'b1, 1'b1, 1'b0));
		add_row(CH_BSLASH, 1'b0, 0, '0);
		add_row(CH_N, 1'b0, 1, decoded(CODE_LF, 1'b1, 1'b1, 1'b0));
		add_row(CH_BSLASH, 1'b0, 0, '0);
		add_row(CH_R, 1'b0, 1, decoded(CODE_CR, 1'b1, 1'b1, 1'b0));
		add_row(CH_BSLASH, 1'b0, 0, '0);
		add_row(CH_T, 1'b0, 1, decoded(CODE_HT, 1'b1, 1'b1, 1'b0));
		add_row(CH_BSLASH, 1'b0, 0, '0);
		add_row(CH_V, 1'b0, 1, decoded(CODE_VT, 1'b1, 1'b1, 1'b0));
		// A hex escape with no digits drops out and the next byte is plain.
		add_row(CH_BSLASH, 1'b0, 0, '0);
		add_row(CH_X, 1'b0, 0, '0);
		add_row(8'h47, 1'b0, 1, decoded(8'h47, 1'b1, 1'b1, 1'b0));
		add_row(CH_BSLASH, 1'b0, -1, '0);
		add_row(CH_X, 1'b0, -1, '0);
		add_row(CH_UC_F, 1'b0, -1, '0);
		add_row(CH_LC_F, 1'b0, 1, decoded(8'hFF, 1'b1, 1'b1, 1'b0));
		// Three octal sevens overflow eight bits and are truncated.
		add_row(CH_BSLASH, 1'b0, 0, '0);
		add_row(CH_7, 1'b0, 0, '0);
		add_row(CH_7, 1'b0, 0, '0);
		add_row(CH_7, 1'b0, 1, decoded(8'hFF, 1'b1, 1'b1, 1'b0));
		add_row(CH_BSLASH, 1'b0, 0, '0);
		add_row(CH_9 - 8'd1, 1'b0, 1, decoded(CH_9 - 8'd1, 1'b1, 1'b1, 1'b0));
		add_row(CH_BSLASH, 1'b1, 1, decoded(8'h00, 1'b0, 1'b1, 1'b1));
		// A pending octal number is cut short by a non-digit on the last byte.
		add_row(CH_BSLASH, 1'b0, -1, '0);
		add_row(CH_7, 1'b0, -1, '0);
		add_row(CH_9, 1'b1, -1, '0);

		foreach (rows[i])
			send_item(rows[i].ch, rows[i].fin, rows[i].n_typed, rows[i].typed_res);

		run_phase(0, 0, PHASE_ITEMS);
		run_phase(83, 0, PHASE_ITEMS);
		run_phase(0, 83, PHASE_ITEMS);
		run_phase(23, 23, PHASE_ITEMS);

		item_valid <= 1'b0;
		while (expected_out.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_out.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Result side: check every transfer against the oldest expectation.
	always @(posedge clk) begin
		res_t exp_res;
		cycles = cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else if (arst_n) begin
			if (result_valid === 1'b1 && result_stall === 1'b0) begin
				if (expected_out.size() == 0) begin
					report($sformatf("unexpected result char %h valid %b last %b done %b",
						out_char, char_valid, run_last, string_done));
				end else begin
					exp_res = expected_out.pop_front();
					if (out_char !== exp_res.data || char_valid !== exp_res.char_valid ||
							run_last !== exp_res.run_last ||
							string_done !== exp_res.string_done)
						report($sformatf({"expected char %h valid %b last %b done %b, ",
							"got char %h valid %b last %b done %b"},
							exp_res.data, exp_res.char_valid, exp_res.run_last,
							exp_res.string_done, out_char, char_valid, run_last,
							string_done));
				end
			end
			result_stall <= ($urandom_range(99) < stall_pct);
		end
	end

endmodule
